[design/dlrc_pkg.sv]
// Package for the dark line row centroid block.
// Holds the configuration register map, reset values, default sizes and the
// types shared by the row tracker, the divider and the top level.
`default_nettype none

package dlrc_pkg;

	// Default sizes, handed to the top-level parameters
	localparam int DefMaxRows  = 64;
	localparam int DefMaxWidth = 256;

	// Configuration register map
	typedef enum logic [1:0] {
		REG_DARK_THRESHOLD = 2'd0,
		REG_STUCK_VALUE    = 2'd1,
		REG_STUCK_COLUMN   = 2'd2,
		REG_MIN_ROWS       = 2'd3
	} cfg_index_t;

	// Register values after reset
	localparam logic [7:0] RstDarkThreshold = 8'd50;
	localparam logic [7:0] RstStuckValue    = 8'd16;
	localparam logic [7:0] RstStuckColumn   = 8'd174;
	localparam logic [6:0] RstMinRows       = 7'd2;

	// Row minimum value at the start of a row
	localparam logic [7:0] RowMinInit = 8'd255;

	typedef struct packed {
		logic [7:0] dark_threshold;
		logic [7:0] stuck_value;
		logic [7:0] stuck_column;
		logic [6:0] min_rows;
	} cfg_t;

	// Divider sequencer states
	typedef enum logic [2:0] {
		DIV_IDLE = 3'b001,
		DIV_RUN  = 3'b010,
		DIV_DONE = 3'b100
	} div_state_t;

	// Divider status seen by the top level
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

[design/dark_line_row_centroid_core.sv]
// Top level of the dark line row centroid block: configuration registers,
// row tracker, divider and result register.
// Depends on dlrc_pkg, dlrc_row_tracker and dlrc_divider.
//
// Usage: pixels arrive on the pixel channel (pixel_valid/pixel_stall) in
// row-major order, one word per cycle, with row_end on the last pixel of a
// row and frame_end on the last pixel of the frame. Within a frame the block
// takes one pixel per cycle and never stalls. A frame-end word starts the
// mean-column division: the divider yields one quotient bit per cycle of a
// quotient of SumW = clog2(MAX_ROWS * (MAX_WIDTH - 1) + 1) bits (14 by
// default), and the result word then appears on the result channel.
// pixel_stall is high from the acceptance of the frame-end word until the
// result enters the output register. If the receiver holds result_stall,
// the result waits in the output register while the next frame's pixels
// keep flowing; only the following frame's result then waits in the divider
// for it to be taken. Reset clears the row tracker and divider state and
// result_valid, and returns the configuration registers to their defaults.
// Configuration is written through cfg_write, cfg_index and cfg_data; the
// user must write it only while the block is idle, as the block does not enforce this.
`default_nettype none

module dark_line_row_centroid_core #(
	parameter int MAX_ROWS  = dlrc_pkg::DefMaxRows,
	parameter int MAX_WIDTH = dlrc_pkg::DefMaxWidth
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_write,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       pixel_valid,
	output logic            pixel_stall,
	input  wire logic [7:0] pixel_value,
	input  wire logic       row_end,
	input  wire logic       frame_end,
	output logic            result_valid,
	input  wire logic       result_stall,
	output logic [7:0]      mean_column,
	output logic            line_found,
	output logic [6:0]      row_count,
	output logic [8:0]      row_width
);
	import dlrc_pkg::*;

	localparam int SumW = $clog2(MAX_ROWS * (MAX_WIDTH - 1) + 1);
	localparam int RowW = $clog2(MAX_ROWS + 1);

	cfg_t            cfg_q;
	logic            accept;
	logic            frame_accept;
	logic [SumW-1:0] frame_sum;
	logic [RowW-1:0] frame_rows;
	logic [8:0]      frame_width;
	div_stat_t       div_stat;
	logic [SumW-1:0] quotient;
	logic            load;

	logic            found_q;
	logic [6:0]      rows_q;
	logic [8:0]      width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dark_threshold <= RstDarkThreshold;
			cfg_q.stuck_value    <= RstStuckValue;
			cfg_q.stuck_column   <= RstStuckColumn;
			cfg_q.min_rows       <= RstMinRows;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_DARK_THRESHOLD: cfg_q.dark_threshold <= cfg_data;
				REG_STUCK_VALUE:    cfg_q.stuck_value    <= cfg_data;
				REG_STUCK_COLUMN:   cfg_q.stuck_column   <= cfg_data;
				REG_MIN_ROWS:       cfg_q.min_rows       <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	assign pixel_stall  = div_stat.busy | div_stat.done;
	assign accept       = pixel_valid & ~pixel_stall;
	assign frame_accept = accept & frame_end;

	dlrc_row_tracker #(
		.MAX_ROWS  (MAX_ROWS),
		.MAX_WIDTH (MAX_WIDTH),
		.SumW      (SumW),
		.RowW      (RowW)
	) u_tracker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.accept      (accept),
		.pixel_value (pixel_value),
		.row_end     (row_end),
		.frame_end   (frame_end),
		.frame_sum   (frame_sum),
		.frame_rows  (frame_rows),
		.frame_width (frame_width)
	);

	dlrc_divider #(
		.DividendW (SumW),
		.DivisorW  (RowW)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (frame_accept),
		.dividend (frame_sum),
		.divisor  (frame_rows),
		.ack      (load),
		.stat     (div_stat),
		.quotient (quotient)
	);

	// Frame summary held while the division runs
	always_ff @(posedge clk) begin
		if (frame_accept) begin
			found_q <= (frame_rows != '0) && (8'(frame_rows) >= 8'(cfg_q.min_rows));
			rows_q  <= 7'(frame_rows);
			width_q <= frame_width;
		end
	end

	assign load = div_stat.done & (~result_valid | ~result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (load) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	// A mean is only given when the line is found; otherwise it reads zero
	always_ff @(posedge clk) begin
		if (load) begin
			mean_column <= found_q ? 8'(quotient) : 8'd0;
			line_found  <= found_q;
			row_count   <= rows_q;
			row_width   <= width_q;
		end
	end

	a_frame_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		frame_accept |=> div_stat.busy)
		else $error("frame end accepted without starting the division");

	a_div_status_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(div_stat.busy && div_stat.done))
		else $error("divider reports busy and done together");

	a_load_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (result_valid && !div_stat.done && !div_stat.busy))
		else $error("result load did not reach the output register");

	a_no_pixel_while_dividing: assert property (@(posedge clk) disable iff (!arst_n)
		(div_stat.busy || div_stat.done) |-> !accept)
		else $error("pixel accepted while a frame result is pending");

endmodule

`default_nettype wire

[design/dlrc_row_tracker.sv]
// Per-pixel row tracker: running row minimum, row width and frame totals.
// Depends on dlrc_pkg for the configuration struct and reset constants.
`default_nettype none

module dlrc_row_tracker #(
	parameter int MAX_ROWS  = dlrc_pkg::DefMaxRows,
	parameter int MAX_WIDTH = dlrc_pkg::DefMaxWidth,
	parameter int SumW      = $clog2(MAX_ROWS * (MAX_WIDTH - 1) + 1),
	parameter int RowW      = $clog2(MAX_ROWS + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire dlrc_pkg::cfg_t   cfg,
	input  wire logic             accept,
	input  wire logic [7:0]       pixel_value,
	input  wire logic             row_end,
	input  wire logic             frame_end,
	output logic [SumW-1:0]       frame_sum,
	output logic [RowW-1:0]       frame_rows,
	output logic [8:0]            frame_width
);
	import dlrc_pkg::*;

	localparam int ColW = $clog2(MAX_WIDTH + 1);

	logic [ColW-1:0] col_q;
	logic [7:0]      min_value_q;
	logic [7:0]      min_column_q;
	logic [SumW-1:0] sum_q;
	logic [RowW-1:0] rows_q;
	logic [ColW-1:0] last_width_q;

	logic            in_row;
	logic            take;
	logic [7:0]      min_value_nxt;
	logic [7:0]      min_column_nxt;
	logic [ColW-1:0] col_nxt;
	logic            close_row;
	logic            qualify;
	logic [SumW-1:0] sum_nxt;
	logic [RowW-1:0] rows_nxt;
	logic [ColW-1:0] width_nxt;

	always_comb begin
		in_row = col_q < ColW'(MAX_WIDTH);
		take   = in_row && (pixel_value < min_value_q) && (pixel_value != cfg.stuck_value)
			&& (9'(col_q) != 9'(cfg.stuck_column));
		min_value_nxt  = take ? pixel_value : min_value_q;
		min_column_nxt = take ? 8'(col_q) : min_column_q;
		col_nxt        = in_row ? col_q + ColW'(1) : col_q;
		close_row      = row_end || frame_end;
		// Rows past the limit are dropped rather than counted
		qualify  = close_row && (min_value_nxt < cfg.dark_threshold)
			&& (rows_q < RowW'(MAX_ROWS));
		sum_nxt  = qualify ? sum_q + SumW'(min_column_nxt) : sum_q;
		rows_nxt = qualify ? rows_q + RowW'(1) : rows_q;
		width_nxt = close_row ? col_nxt : last_width_q;
	end

	assign frame_sum   = sum_nxt;
	assign frame_rows  = rows_nxt;
	assign frame_width = 9'(width_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			min_value_q  <= RowMinInit;
			min_column_q <= '0;
			sum_q        <= '0;
			rows_q       <= '0;
			last_width_q <= '0;
		end else if (accept) begin
			last_width_q <= width_nxt;
			if (close_row) begin
				col_q        <= '0;
				min_value_q  <= RowMinInit;
				min_column_q <= '0;
			end else begin
				col_q        <= col_nxt;
				min_value_q  <= min_value_nxt;
				min_column_q <= min_column_nxt;
			end
			if (frame_end) begin
				sum_q  <= '0;
				rows_q <= '0;
			end else begin
				sum_q  <= sum_nxt;
				rows_q <= rows_nxt;
			end
		end
	end

endmodule

`default_nettype wire

[design/dlrc_divider.sv]
// Restoring divider, one quotient bit per cycle under a small sequencer.
// Depends on dlrc_pkg for the sequencer state and status types.
`default_nettype none

module dlrc_divider #(
	parameter int DividendW = 14,
	parameter int DivisorW  = 7
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DividendW-1:0]  dividend,
	input  wire logic [DivisorW-1:0]   divisor,
	input  wire logic                  ack,
	output dlrc_pkg::div_stat_t        stat,
	output logic [DividendW-1:0]       quotient
);
	import dlrc_pkg::*;

	localparam int CntW = $clog2(DividendW + 1);

	div_state_t           state_q;
	logic [CntW-1:0]      cnt_q;
	logic [DivisorW-1:0]  rem_q;
	logic [DividendW-1:0] quo_q;
	logic [DivisorW-1:0]  den_q;

	logic [DivisorW:0]    shifted;
	logic                 fits;

	always_comb begin
		shifted = {rem_q, quo_q[DividendW-1]};
		fits    = shifted >= {1'b0, den_q};
	end

	assign stat.busy = state_q == DIV_RUN;
	assign stat.done = state_q == DIV_DONE;
	assign quotient  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				DIV_IDLE: begin
					if (start) begin
						state_q <= DIV_RUN;
						cnt_q   <= CntW'(DividendW);
					end
				end
				DIV_RUN: begin
					cnt_q <= cnt_q - CntW'(1);
					if (cnt_q == CntW'(1)) begin
						state_q <= DIV_DONE;
					end
				end
				DIV_DONE: begin
					if (ack) begin
						state_q <= DIV_IDLE;
					end
				end
				default: state_q <= DIV_IDLE;
			endcase
		end
	end

	// The dividend shifts out of the top of quo_q as quotient bits shift in
	always_ff @(posedge clk) begin
		if (state_q == DIV_IDLE && start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (state_q == DIV_RUN) begin
			rem_q <= fits ? DivisorW'(shifted - {1'b0, den_q}) : DivisorW'(shifted);
			quo_q <= {quo_q[DividendW-2:0], fits};
		end
	end

endmodule

`default_nettype wire
